### src/assert_macros.svh
// Assertion macros for the checker of the serial frame receiver.
// Depends on nothing; included by the checker module only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define SFR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/sfr_pkg.sv
// Package of the serial frame receiver: phase codes, status codes, result word type
// and the reflected CRC-8 byte update. Depends on nothing.
package sfr_pkg;

   localparam int MAX_DATA_DEFAULT = 8;

   localparam logic [7:0] HDR_FIRST  = 8'h55;
   localparam logic [7:0] HDR_SECOND = 8'hAA;
   localparam logic [7:0] CRC_POLY   = 8'h8C;

   // Data bytes that are kept for the result word.
   localparam int KEEP_COUNT = 3;
   localparam int KEEP_IDX_W = 2;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_CRC    = 2'd1;
   localparam logic [1:0] STATUS_LENGTH = 2'd2;

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_LEN    = 3'd1,
      PH_DATA   = 3'd2,
      PH_CRC    = 3'd3,
      PH_TRAIL1 = 3'd4,
      PH_TRAIL2 = 3'd5
   } phase_type;

   typedef struct packed {
      logic signed [15:0] control_value;
      logic [7:0]         control_flag;
      logic [1:0]         frame_status;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } rsp_push_type;

   // One byte through the LSB-first CRC-8 shift register.
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // CRC after the two header bytes, seen from a zero start.
   localparam logic [7:0] HDR_CRC = crc8_feed(crc8_feed(8'h00, HDR_FIRST), HDR_SECOND);

endpackage

### src/sfr_parser.sv
// Frame parser: header hunt, length check, data capture and CRC-8 check, one byte per
// cycle in which accept is high. Depends on sfr_pkg.
module sfr_parser #(
   parameter int MAX_DATA = sfr_pkg::MAX_DATA_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           rx_byte,
   output sfr_pkg::rsp_push_type push
);

   localparam int CW = $clog2(MAX_DATA + 1);
   localparam logic [7:0] MAX_B = 8'(MAX_DATA);

   sfr_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         prev_ff, prev_in;
   logic [CW-1:0]      len_ff, len_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [7:0]         crc_ff, crc_in;
   logic [7:0]         keep_ff [sfr_pkg::KEEP_COUNT];

   logic                          keep_we;
   logic [sfr_pkg::KEEP_IDX_W-1:0] keep_idx;
   logic [CW-1:0]                 cnt_next;
   logic [7:0]                    crc_upd;

   assign cnt_next = cnt_ff + CW'(1);
   assign crc_upd  = sfr_pkg::crc8_feed(crc_ff, rx_byte);

   always_comb begin
      phase_in = phase_ff;
      prev_in  = prev_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      crc_in   = crc_ff;
      keep_we  = 1'b0;
      keep_idx = cnt_ff[sfr_pkg::KEEP_IDX_W-1:0];
      push.valid              = 1'b0;
      push.data.control_value = '0;
      push.data.control_flag  = '0;
      push.data.frame_status  = sfr_pkg::STATUS_OK;
      if (accept) begin
         unique case (phase_ff)
            sfr_pkg::PH_LEN: begin
               if (rx_byte < 8'd2 || rx_byte > MAX_B) begin
                  push.valid             = 1'b1;
                  push.data.frame_status = sfr_pkg::STATUS_LENGTH;
               end else begin
                  len_in   = CW'(rx_byte);
                  crc_in   = crc_upd;
                  cnt_in   = '0;
                  phase_in = sfr_pkg::PH_DATA;
               end
            end
            sfr_pkg::PH_DATA: begin
               if (cnt_ff < CW'(sfr_pkg::KEEP_COUNT)) begin
                  keep_we = 1'b1;
               end
               crc_in = crc_upd;
               cnt_in = cnt_next;
               if (cnt_next >= len_ff) begin
                  phase_in = sfr_pkg::PH_CRC;
               end
            end
            sfr_pkg::PH_CRC: begin
               if (rx_byte != crc_ff) begin
                  push.valid             = 1'b1;
                  push.data.frame_status = sfr_pkg::STATUS_CRC;
               end else begin
                  // With only two data bytes, the CRC byte sits at position five.
                  if (len_ff == CW'(2)) begin
                     keep_we  = 1'b1;
                     keep_idx = sfr_pkg::KEEP_IDX_W'(2);
                  end
                  phase_in = sfr_pkg::PH_TRAIL1;
               end
            end
            sfr_pkg::PH_TRAIL1: begin
               phase_in = sfr_pkg::PH_TRAIL2;
            end
            sfr_pkg::PH_TRAIL2: begin
               push.valid              = 1'b1;
               push.data.control_value = {keep_ff[1], keep_ff[0]};
               push.data.control_flag  = keep_ff[2];
               push.data.frame_status  = sfr_pkg::STATUS_OK;
            end
            default: begin
               // Header hunt; an unused phase code behaves the same way.
               phase_in = sfr_pkg::PH_HUNT;
               if (rx_byte == sfr_pkg::HDR_SECOND) begin
                  if (prev_ff == sfr_pkg::HDR_FIRST) begin
                     crc_in   = sfr_pkg::HDR_CRC;
                     cnt_in   = '0;
                     len_in   = '0;
                     phase_in = sfr_pkg::PH_LEN;
                  end
               end else begin
                  prev_in = rx_byte;
               end
            end
         endcase
         if (push.valid) begin
            phase_in = sfr_pkg::PH_HUNT;
            prev_in  = '0;
            len_in   = '0;
            cnt_in   = '0;
            crc_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sfr_pkg::PH_HUNT;
         prev_ff  <= '0;
         len_ff   <= '0;
         cnt_ff   <= '0;
         crc_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         crc_ff   <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (keep_we) begin
         keep_ff[keep_idx] <= rx_byte;
      end
   end

endmodule

### src/sfr_rsp_buf.sv
// Result output register with one skid entry, so that input keeps flowing while a
// finished word waits. Depends on sfr_pkg.
module sfr_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  sfr_pkg::rsp_push_type push,
   input  logic                  out_ready,
   output logic                  out_valid,
   output sfr_pkg::rsp_type      out_data,
   output logic                  in_ready
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   sfr_pkg::rsp_type out_data_ff, out_data_in;
   sfr_pkg::rsp_type skid_data_ff, skid_data_in;
   logic             pop;

   assign pop = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      // A push only happens while the skid entry is empty.
      priority if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push.valid) begin
         if (out_valid_ff && !pop) begin
            skid_data_in  = push.data;
            skid_valid_in = 1'b1;
         end else begin
            out_data_in  = push.data;
            out_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign in_ready  = !skid_valid_ff;

endmodule

### src/serial_frame_receiver_crc8_unit.sv
// Top level of the serial frame receiver with CRC-8 check.
// Depends on sfr_pkg, sfr_parser and sfr_rsp_buf.
//
// Usage: received serial bytes enter one word per handshake on the req_ channel
// (req_valid, req_ready, req_rx_byte). The receiver hunts for the header 0x55 0xAA,
// then takes a length byte, that many data bytes, a CRC byte and two trailer bytes.
// A complete frame, a CRC mismatch or a bad length each produce one result word on
// the rsp_ channel: control value, flag byte and a status code. All other bytes
// produce no result.
// Results: the word for the byte that completes or rejects the frame is registered in
// the output register, or in the skid entry while the output word is not being taken.
// Throughput: one byte per cycle while req_ready is high. The parser settles each byte
// in a single pass between its state registers and the result register.
// Stalls: while rsp_ready is low, one finished word waits in the output register and
// a second one in a skid entry; req_ready drops only when that skid entry is full.
// Reset: synchronous and active high; it returns the receiver to header hunting,
// clears the running CRC and counters, and empties the output register and skid.
module serial_frame_receiver_crc8_unit #(
   parameter int MAX_DATA = sfr_pkg::MAX_DATA_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_control_value,
   output logic [7:0]         rsp_control_flag,
   output logic [1:0]         rsp_frame_status
);

   logic                  accept;
   sfr_pkg::rsp_push_type push;
   sfr_pkg::rsp_type      rsp_data;

   assign accept = req_valid && req_ready;

   // Byte parser; raises push.valid for the byte that ends or rejects a frame.
   sfr_parser #(
      .MAX_DATA (MAX_DATA)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .push    (push)
   );

   // Output register plus skid entry between the parser and the rsp_ channel.
   sfr_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .in_ready  (req_ready)
   );

   assign rsp_control_value = rsp_data.control_value;
   assign rsp_control_flag  = rsp_data.control_flag;
   assign rsp_frame_status  = rsp_data.frame_status;

endmodule

### src/sfr_checker.sv
// Port-level checker of the serial frame receiver, bound to the top level.
// Depends on sfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_control_value,
   input logic [7:0]         rsp_control_flag,
   input logic [1:0]         rsp_frame_status
);

   logic        req_accept;
   logic        rsp_stall;
   logic        status_known;
   logic        error_word;
   logic        data_zero;
   logic [25:0] rsp_word;

   assign req_accept   = req_valid && req_ready;
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign status_known = (rsp_frame_status == sfr_pkg::STATUS_OK) ||
                         (rsp_frame_status == sfr_pkg::STATUS_CRC) ||
                         (rsp_frame_status == sfr_pkg::STATUS_LENGTH);
   assign error_word   = rsp_valid && (rsp_frame_status != sfr_pkg::STATUS_OK);
   assign data_zero    = (rsp_control_value == 16'sd0) && (rsp_control_flag == 8'd0);
   assign rsp_word     = {rsp_control_value, rsp_control_flag, rsp_frame_status};

   // A rise of rsp_valid always comes from a byte taken in the cycle before.
   `SFR_ASSERT(a_status_code, clock, reset, rsp_valid |-> status_known, "unknown frame status")
   `SFR_ASSERT(a_error_zero, clock, reset, error_word |-> data_zero, "error word carries data")
   `SFR_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> (rsp_valid && $stable(rsp_word)), "stalled word changed")
   `SFR_ASSERT(a_word_cause, clock, reset, $rose(rsp_valid) |-> $past(req_accept), "word without a byte")
   `SFR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (!rsp_valid && req_ready), "not empty after reset")

endmodule

bind serial_frame_receiver_crc8_unit sfr_checker u_sfr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_control_value (rsp_control_value),
   .rsp_control_flag  (rsp_control_flag),
   .rsp_frame_status  (rsp_frame_status)
);

### tb/tb_top.sv
// Self-checking testbench for serial_frame_receiver_crc8_unit: directed and random byte streams.
// Depends on sfr_pkg and the receiver RTL; it has its own model of the frame parser.
module tb_top;

   localparam int FRAME_MAX    = sfr_pkg::MAX_DATA_DEFAULT;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 12;
   localparam int REPORT_MAX   = 10;

   typedef logic [7:0] byte_q_type [$];

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_rx_byte;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_control_value;
   logic [7:0]         rsp_control_flag;
   logic [1:0]         rsp_frame_status;

   // State of the parser model. It mirrors the receiver: phase, the byte seen last
   // while hunting, the length, the data count, the running CRC and the kept bytes.
   sfr_pkg::phase_type rx_phase;
   logic [7:0]         rx_last_byte;
   logic [3:0]         rx_length;
   logic [3:0]         rx_count;
   logic [7:0]         rx_crc;
   logic [7:0]         rx_kept [sfr_pkg::KEEP_COUNT];

   // Result words that the receiver still owes, oldest first.
   sfr_pkg::rsp_type expected_results [$];
   sfr_pkg::rsp_type oldest_result;

   int error_count    = 0;
   int bytes_sent     = 0;
   int frames_ok      = 0;
   int frames_bad_crc = 0;
   int frames_bad_len = 0;
   int cycle_count    = 0;

   // Controls for the idling of both sides. The receiver counts its long hold-off
   // itself; a test only loads the number of cycles.
   bit sender_gaps_on     = 1'b1;
   bit receiver_stalls_on = 1'b1;
   int hold_off_left      = 0;

   serial_frame_receiver_crc8_unit #(
      .MAX_DATA (FRAME_MAX)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_control_value (rsp_control_value),
      .rsp_control_flag  (rsp_control_flag),
      .rsp_frame_status  (rsp_frame_status)
   );

   always #4 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Parser model
   // ---------------------------------------------------------------------------

   // Reflected CRC-8, one byte, least significant bit first.
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] acc;
      acc = crc ^ b;
      for (int bit_idx = 0; bit_idx < 8; bit_idx++) begin
         acc = acc[0] ? ((acc >> 1) ^ sfr_pkg::CRC_POLY) : (acc >> 1);
      end
      return acc;
   endfunction

   // Every result puts the parser back into header hunting with cleared counters.
   // The kept bytes survive, as they do in the receiver.
   task automatic clear_frame_state();
      rx_phase     = sfr_pkg::PH_HUNT;
      rx_last_byte = 8'h00;
      rx_length    = 4'd0;
      rx_count     = 4'd0;
      rx_crc       = 8'h00;
   endtask

   task automatic expect_result(input logic [15:0] value, input logic [7:0] flag,
                                input logic [1:0] status);
      sfr_pkg::rsp_type word;
      word.control_value = value;
      word.control_flag  = flag;
      word.frame_status  = status;
      expected_results.push_back(word);
      clear_frame_state();
   endtask

   // Advances the model by one accepted byte and queues the result it causes.
   task automatic predict_byte(input logic [7:0] b);
      case (rx_phase)
         sfr_pkg::PH_LEN: begin
            if (b < 8'd2 || b > FRAME_MAX) begin
               expect_result(16'h0000, 8'h00, sfr_pkg::STATUS_LENGTH);
            end else begin
               rx_length = b[3:0];
               rx_crc    = crc8_step(rx_crc, b);
               rx_count  = 4'd0;
               rx_phase  = sfr_pkg::PH_DATA;
            end
         end
         sfr_pkg::PH_DATA: begin
            if (rx_count < sfr_pkg::KEEP_COUNT) begin
               rx_kept[rx_count] = b;
            end
            rx_crc   = crc8_step(rx_crc, b);
            rx_count = rx_count + 4'd1;
            if (rx_count >= rx_length) begin
               rx_phase = sfr_pkg::PH_CRC;
            end
         end
         sfr_pkg::PH_CRC: begin
            if (b != rx_crc) begin
               expect_result(16'h0000, 8'h00, sfr_pkg::STATUS_CRC);
            end else begin
               // With only two data bytes the flag is the CRC byte itself.
               if (rx_length == 4'd2) begin
                  rx_kept[2] = b;
               end
               rx_phase = sfr_pkg::PH_TRAIL1;
            end
         end
         sfr_pkg::PH_TRAIL1: begin
            rx_phase = sfr_pkg::PH_TRAIL2;
         end
         sfr_pkg::PH_TRAIL2: begin
            expect_result({rx_kept[1], rx_kept[0]}, rx_kept[2], sfr_pkg::STATUS_OK);
         end
         default: begin
            // Header hunt. A 0xAA only counts after a remembered 0x55, and it is
            // never itself remembered.
            if (b == sfr_pkg::HDR_SECOND) begin
               if (rx_last_byte == sfr_pkg::HDR_FIRST) begin
                  rx_crc    = crc8_step(crc8_step(8'h00, sfr_pkg::HDR_FIRST),
                                        sfr_pkg::HDR_SECOND);
                  rx_count  = 4'd0;
                  rx_length = 4'd0;
                  rx_phase  = sfr_pkg::PH_LEN;
               end
            end else begin
               rx_last_byte = b;
            end
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // Frame builders
   // ---------------------------------------------------------------------------

   // Header, length, data, CRC and two trailer bytes. A nonzero crc_error corrupts the
   // CRC byte, and such a frame stops there since the receiver resyncs on the bad CRC.
   function automatic byte_q_type make_frame(input byte_q_type payload,
                                             input logic [7:0] crc_error,
                                             input logic [7:0] trail_a,
                                             input logic [7:0] trail_b);
      byte_q_type frame;
      logic [7:0] crc;
      frame = {sfr_pkg::HDR_FIRST, sfr_pkg::HDR_SECOND, 8'(payload.size())};
      crc   = 8'h00;
      foreach (frame[i]) begin
         crc = crc8_step(crc, frame[i]);
      end
      foreach (payload[i]) begin
         frame.push_back(payload[i]);
         crc = crc8_step(crc, payload[i]);
      end
      frame.push_back(crc ^ crc_error);
      if (crc_error == 8'h00) begin
         frame.push_back(trail_a);
         frame.push_back(trail_b);
      end
      return frame;
   endfunction

   // Random data, with the zero, all-ones and sign-edge patterns turning up often.
   function automatic byte_q_type random_payload(input int count);
      byte_q_type payload;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 11))
            0:       payload.push_back(8'h00);
            1:       payload.push_back(8'hFF);
            2:       payload.push_back(8'h80);
            3:       payload.push_back(8'h7F);
            default: payload.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      return payload;
   endfunction

   // Mostly the shortest and longest lengths: the shortest bends the flag rule, the longest sits on the bound.
   function automatic int random_length();
      case ($urandom_range(0, 2))
         0:       return 2;
         1:       return FRAME_MAX;
         default: return $urandom_range(2, FRAME_MAX);
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Sender, receiver and checker
   // ---------------------------------------------------------------------------

   // Offers one byte and returns at the falling edge after it was accepted, with
   // valid still high so that back-to-back words need no second assignment.
   task automatic send_byte(input logic [7:0] value);
      int gap;
      if (sender_gaps_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predict_byte(value);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_bytes(input byte_q_type stream);
      foreach (stream[i]) begin
         send_byte(stream[i]);
      end
   endtask

   // Drops valid and waits at the falling edge until every owed word has come.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Result side. A long hold-off takes priority over the short random stalls.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_ready <= 1'b0;
            hold_off_left--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (receiver_stalls_on && $urandom_range(0, 9) == 0) begin
            rsp_ready  <= 1'b0;
            stall_left = $urandom_range(1, 15) - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Every accepted result word is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX) begin
               $display("tb_top: unexpected word value=%0d flag=%02h status=%0d",
                        rsp_control_value, rsp_control_flag, rsp_frame_status);
            end
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_control_value !== oldest_result.control_value ||
                rsp_control_flag !== oldest_result.control_flag ||
                rsp_frame_status !== oldest_result.frame_status) begin
               error_count++;
               if (error_count <= REPORT_MAX) begin
                  $display("tb_top: mismatch at cycle %0d", cycle_count);
                  $display("   expected value=%0d flag=%02h status=%0d",
                           oldest_result.control_value, oldest_result.control_flag,
                           oldest_result.frame_status);
                  $display("   actual   value=%0d flag=%02h status=%0d",
                           rsp_control_value, rsp_control_flag, rsp_frame_status);
               end
            end
            case (oldest_result.frame_status)
               sfr_pkg::STATUS_OK:  frames_ok++;
               sfr_pkg::STATUS_CRC: frames_bad_crc++;
               default:             frames_bad_len++;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Hand-picked frames: the shortest frame with the CRC as flag and the most
   // negative control value, a trailer that looks like a header, a lone 0xAA,
   // a length one above the maximum, a length of zero, and a corrupted CRC.
   task automatic test_header_and_errors();
      // The trailer ends in 0x55 0xAA, but the result clears the remembered byte,
      // so the lone 0xAA that follows must not start a frame.
      send_bytes(make_frame('{8'h00, 8'h80}, 8'h00, sfr_pkg::HDR_FIRST, sfr_pkg::HDR_SECOND));
      send_byte(sfr_pkg::HDR_SECOND);
      // A 0xAA after some other byte does nothing; then a real header with a
      // length one above the maximum.
      send_bytes('{8'h13, sfr_pkg::HDR_SECOND, sfr_pkg::HDR_FIRST, sfr_pkg::HDR_SECOND,
                   8'(FRAME_MAX + 1)});
      // Length zero.
      send_bytes('{sfr_pkg::HDR_FIRST, sfr_pkg::HDR_SECOND, 8'h00});
      // All CRC bits flipped.
      send_bytes(make_frame('{8'hFF, 8'h7F, 8'h5A}, 8'hFF, 8'h00, 8'h00));
   endtask

   // Mostly well-formed frames with random content, plus bad lengths, bad CRCs,
   // cut-off frames and line noise. Noise bytes do not count toward the budget.
   task automatic test_random_frames(input int byte_budget);
      int         counted;
      int         pick;
      int         len;
      byte_q_type frame;
      counted = 0;
      while (counted < byte_budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            frame = make_frame(random_payload(random_length()), 8'h00,
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else if (pick < 80) begin
            case ($urandom_range(0, 3))
               0:       len = 0;
               1:       len = 1;
               2:       len = 255;
               default: len = $urandom_range(FRAME_MAX + 1, 255);
            endcase
            frame = {sfr_pkg::HDR_FIRST, sfr_pkg::HDR_SECOND, 8'(len)};
         end else if (pick < 90) begin
            frame = make_frame(random_payload(random_length()),
                               8'($urandom_range(1, 255)), 8'h00, 8'h00);
         end else if (pick < 95) begin
            // Frame cut short; the next frame's bytes run into it.
            frame = make_frame(random_payload(random_length()), 8'h00, 8'h00, 8'h00);
            frame = frame[0 : $urandom_range(2, frame.size() - 2)];
         end else begin
            frame = random_payload($urandom_range(1, 6));
            send_bytes(frame);
            continue;
         end
         send_bytes(frame);
         counted += frame.size();
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // short frames without gaps, so the output register and skid fill up and the
   // receiver has to drop req_ready.
   task automatic test_output_backpressure();
      sender_gaps_on = 1'b0;
      hold_off_left  = 80;
      for (int i = 0; i < 8; i++) begin
         send_bytes({sfr_pkg::HDR_FIRST, sfr_pkg::HDR_SECOND, 8'($urandom_range(0, 1))});
      end
      send_bytes(make_frame(random_payload(2), 8'h00, 8'h00, 8'h00));
      send_bytes(make_frame(random_payload(FRAME_MAX), 8'h00, 8'h00, 8'h00));
      sender_gaps_on = 1'b1;
   endtask

   // The sender stops until every owed word has arrived, then carries on.
   task automatic test_pause_until_drained();
      send_bytes(make_frame(random_payload(random_length()), 8'h00, 8'h00, 8'h00));
      wait_until_drained();
      send_bytes(make_frame(random_payload(random_length()), 8'h00, 8'h00, 8'h00));
      send_bytes(make_frame(random_payload(3), 8'h01, 8'h00, 8'h00));
   endtask

   // Last part: no idling on either side, words back to back.
   task automatic test_steady_stream(input int byte_budget);
      sender_gaps_on     = 1'b0;
      receiver_stalls_on = 1'b0;
      test_random_frames(byte_budget);
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      clear_frame_state();
      foreach (rx_kept[i]) begin
         rx_kept[i] = 8'h00;
      end
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_header_and_errors();
      test_random_frames(240);
      test_output_backpressure();
      test_pause_until_drained();
      test_steady_stream(100);

      // Everything owed must arrive, and nothing more may follow it.
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_results.size() != 0) begin
         error_count += expected_results.size();
         $display("tb_top: %0d result words never arrived", expected_results.size());
      end

      $display("tb_top: %0d bytes sent; checked %0d good frames,", bytes_sent, frames_ok);
      $display("tb_top: %0d CRC errors and %0d bad lengths, %0d failures in %0d cycles",
               frames_bad_crc, frames_bad_len, error_count, cycle_count);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+src
src/sfr_pkg.sv
src/sfr_parser.sv
src/sfr_rsp_buf.sv
src/serial_frame_receiver_crc8_unit.sv
src/sfr_checker.sv
tb/tb_top.sv
